FILE: sv/psa_pkg.sv
package psa_pkg;

    localparam int DEBOUNCE_W = 10;
    localparam int WINDOW_W   = 13;
    localparam int TIMEOUT_W  = 12;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int SINCE_W    = 16;
    localparam int ELAPSED_W  = 22;
    localparam int COUNT_W    = 2;
    localparam int STEP_IDX_W = 6;

    localparam int STEP_PERIOD_MS_DEF = 100;
    localparam int MS_PER_S           = 1000;
    localparam int SOS_STEPS          = 46;

    localparam logic [SINCE_W-1:0]   SINCE_MAX   = '1;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
    localparam logic [COUNT_W-1:0]   COUNT_MAX   = '1;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST  = DEBOUNCE_W'(50);
    localparam logic [WINDOW_W-1:0]   WINDOW_RST    = WINDOW_W'(500);
    localparam logic [ELAPSED_W-1:0]  TIMEOUT_THR_RST = ELAPSED_W'(60 * MS_PER_S);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE = 2'd0,
        CFG_WINDOW   = 2'd1,
        CFG_TIMEOUT  = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [DEBOUNCE_W-1:0] debounce_ms;
        logic [WINDOW_W-1:0]   window_ms;
        logic [ELAPSED_W-1:0]  timeout_thr_ms;
    } psa_cfg_t;

    typedef struct packed {
        logic buzzer;
        logic led;
        logic alert_on;
        logic alarm_on;
        logic alert_fired;
        logic alert_loud;
    } psa_result_t;

    function automatic logic sos_level(input logic [STEP_IDX_W-1:0] s);
        logic lvl;
        lvl = 1'b0;
        case (1'b1)
            (s < STEP_IDX_W'(6)):                          lvl = ~s[0];
            (s >= STEP_IDX_W'(12) && s < STEP_IDX_W'(24)): lvl = (s[1:0] != 2'd3);
            (s >= STEP_IDX_W'(30) && s < STEP_IDX_W'(36)): lvl = ~s[0];
            default:                                       lvl = 1'b0;
        endcase
        return lvl;
    endfunction

endpackage

FILE: sv/psa_if.sv
interface psa_in_if;
    logic valid;
    logic ready;
    logic button_fall;

    modport source (output valid, output button_fall, input ready);
    modport sink (input valid, input button_fall, output ready);
endinterface

interface psa_out_if;
    logic valid;
    logic ready;
    logic buzzer;
    logic led;
    logic alert_on;
    logic alarm_on;
    logic alert_fired;
    logic alert_loud;

    modport source (
        output valid, output buzzer, output led, output alert_on,
        output alarm_on, output alert_fired, output alert_loud,
        input ready
    );
    modport sink (
        input valid, input buzzer, input led, input alert_on,
        input alarm_on, input alert_fired, input alert_loud,
        output ready
    );
endinterface

FILE: sv/panic_button_sos_alarm_controller_top.sv
// channel  dir  handshake          payload
// tick     in   valid/ready        button_fall
// status   out  valid/ready        buzzer led alert_on alarm_on alert_fired alert_loud
// cfg      in   cfg_we, no wait    cfg_index 0 debounce, 1 window, 2 timeout; cfg_data
//
// one tick per cycle sustained while status is not stalled; a tick's status passes
// through the input register, then the status register behind the tick update logic
// rst_n low clears all timers, the press and alert state and loads default settings
// a stalled status holds the pipe; a tick is still taken while the input slot is free

module panic_button_sos_alarm_controller_top #(
    parameter int STEP_PERIOD_MS = psa_pkg::STEP_PERIOD_MS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [psa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [psa_pkg::CFG_DATA_W-1:0] cfg_data,
    psa_in_if.sink                         tick,
    psa_out_if.source                      status
);
    import psa_pkg::*;

    psa_cfg_t    cfg;
    psa_result_t result;
    psa_result_t status_reg;
    logic        s1_valid_reg;
    logic        s1_fall_reg;
    logic        status_valid_reg;
    logic        advance;

    assign advance    = s1_valid_reg && (!status_valid_reg || status.ready);
    assign tick.ready = !s1_valid_reg || advance;

    psa_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    psa_core #(
        .STEP_PERIOD_MS (STEP_PERIOD_MS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .button_fall (s1_fall_reg),
        .cfg         (cfg),
        .result      (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            status_valid_reg <= 1'b0;
        end
        else
        begin
            if (tick.ready)
                s1_valid_reg <= tick.valid;
            if (advance)
                status_valid_reg <= 1'b1;
            else if (status.ready)
                status_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick.ready && tick.valid)
            s1_fall_reg <= tick.button_fall;
        if (advance)
            status_reg <= result;
    end

    assign status.valid       = status_valid_reg;
    assign status.buzzer      = status_reg.buzzer;
    assign status.led         = status_reg.led;
    assign status.alert_on    = status_reg.alert_on;
    assign status.alarm_on    = status_reg.alarm_on;
    assign status.alert_fired = status_reg.alert_fired;
    assign status.alert_loud  = status_reg.alert_loud;

endmodule

FILE: sv/psa_cfg.sv
module psa_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [psa_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [psa_pkg::CFG_DATA_W-1:0]      cfg_data,
    output psa_pkg::psa_cfg_t                   cfg
);
    import psa_pkg::*;

    logic [DEBOUNCE_W-1:0] debounce_reg;
    logic [WINDOW_W-1:0]   window_reg;
    logic [ELAPSED_W-1:0]  timeout_thr_reg;
    logic [ELAPSED_W-1:0]  timeout_thr_next;

    // timeout kept in ms so the check is a plain compare
    assign timeout_thr_next = ELAPSED_W'(cfg_data[TIMEOUT_W-1:0]) * ELAPSED_W'(MS_PER_S);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg    <= DEBOUNCE_RST;
            window_reg      <= WINDOW_RST;
            timeout_thr_reg <= TIMEOUT_THR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DEBOUNCE: debounce_reg    <= cfg_data[DEBOUNCE_W-1:0];
                CFG_WINDOW:   window_reg      <= cfg_data[WINDOW_W-1:0];
                CFG_TIMEOUT:  timeout_thr_reg <= timeout_thr_next;
                default:      ;
            endcase
        end
    end

    assign cfg.debounce_ms    = debounce_reg;
    assign cfg.window_ms      = window_reg;
    assign cfg.timeout_thr_ms = timeout_thr_reg;

endmodule

FILE: sv/psa_core.sv
module psa_core #(
    parameter int STEP_PERIOD_MS = psa_pkg::STEP_PERIOD_MS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic                 button_fall,
    input  psa_pkg::psa_cfg_t    cfg,
    output psa_pkg::psa_result_t result
);
    import psa_pkg::*;

    localparam int STEP_W = $clog2(STEP_PERIOD_MS + 1);
    localparam logic [STEP_W-1:0] STEP_LIMIT = STEP_W'(STEP_PERIOD_MS);

    logic [SINCE_W-1:0]    since_reg, since_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic                  pending_reg, pending_next;
    logic                  alert_reg, alert_next;
    logic [ELAPSED_W-1:0]  elapsed_reg, elapsed_next;
    logic                  alarm_reg, alarm_next;
    logic [STEP_IDX_W-1:0] step_reg, step_next;
    logic [STEP_W-1:0]     alarm_ms_reg, alarm_ms_next;
    logic                  buzzer_reg, buzzer_next;
    logic                  flashing_reg, flashing_next;
    logic                  phase_reg, phase_next;
    logic [STEP_W-1:0]     led_ms_reg, led_ms_next;
    logic                  led_reg, led_next;
    logic                  fired;
    logic                  loud;
    logic                  waiting;

    always_comb
    begin
        since_next    = (since_reg == SINCE_MAX) ? SINCE_MAX : since_reg + 1'b1;
        elapsed_next  = (elapsed_reg == ELAPSED_MAX) ? ELAPSED_MAX : elapsed_reg + 1'b1;
        alarm_ms_next = (alarm_ms_reg >= STEP_LIMIT) ? STEP_LIMIT : alarm_ms_reg + 1'b1;
        led_ms_next   = (led_ms_reg >= STEP_LIMIT) ? STEP_LIMIT : led_ms_reg + 1'b1;
        count_next    = count_reg;
        pending_next  = pending_reg;
        alert_next    = alert_reg;
        alarm_next    = alarm_reg;
        step_next     = step_reg;
        buzzer_next   = buzzer_reg;
        flashing_next = flashing_reg;
        phase_next    = phase_reg;
        led_next      = led_reg;
        fired         = 1'b0;
        loud          = 1'b0;
        waiting       = 1'b0;

        // debounced press
        if (button_fall && since_next > SINCE_W'(cfg.debounce_ms))
        begin
            if (since_next < SINCE_W'(cfg.window_ms))
                count_next = (count_reg == COUNT_MAX) ? COUNT_MAX : count_reg + 1'b1;
            else
                count_next = COUNT_W'(1);
            since_next   = '0;
            pending_next = 1'b1;
        end

        // resolve pending press
        if (pending_next)
        begin
            waiting = (count_next == COUNT_W'(1)) && (since_next < SINCE_W'(cfg.window_ms));
            if (!waiting)
            begin
                loud = count_next[1];
                if (loud)
                begin
                    if (!alarm_next)
                    begin
                        alarm_next = 1'b1;
                        step_next  = '0;
                    end
                    flashing_next = 1'b1;
                end
                alert_next   = 1'b1;
                elapsed_next = '0;
                fired        = 1'b1;
                count_next   = '0;
                pending_next = 1'b0;
            end
        end

        if (flashing_next && led_ms_next >= STEP_LIMIT)
        begin
            phase_next  = ~phase_next;
            led_next    = phase_next;
            led_ms_next = '0;
        end

        if (alarm_next && alarm_ms_next >= STEP_LIMIT)
        begin
            alarm_ms_next = '0;
            buzzer_next   = sos_level(step_next);
            step_next     = (step_next >= STEP_IDX_W'(SOS_STEPS - 1)) ? '0
                                                                     : step_next + 1'b1;
        end

        // timeout
        if (alert_next && elapsed_next >= cfg.timeout_thr_ms)
        begin
            alarm_next    = 1'b0;
            buzzer_next   = 1'b0;
            flashing_next = 1'b0;
            led_next      = 1'b0;
            alert_next    = 1'b0;
        end

        result.buzzer      = buzzer_next;
        result.led         = led_next;
        result.alert_on    = alert_next;
        result.alarm_on    = alarm_next;
        result.alert_fired = fired;
        result.alert_loud  = fired & loud;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            since_reg    <= '0;
            count_reg    <= '0;
            pending_reg  <= 1'b0;
            alert_reg    <= 1'b0;
            elapsed_reg  <= '0;
            alarm_reg    <= 1'b0;
            step_reg     <= '0;
            alarm_ms_reg <= '0;
            buzzer_reg   <= 1'b0;
            flashing_reg <= 1'b0;
            phase_reg    <= 1'b0;
            led_ms_reg   <= '0;
            led_reg      <= 1'b0;
        end
        else if (advance)
        begin
            since_reg    <= since_next;
            count_reg    <= count_next;
            pending_reg  <= pending_next;
            alert_reg    <= alert_next;
            elapsed_reg  <= elapsed_next;
            alarm_reg    <= alarm_next;
            step_reg     <= step_next;
            alarm_ms_reg <= alarm_ms_next;
            buzzer_reg   <= buzzer_next;
            flashing_reg <= flashing_next;
            phase_reg    <= phase_next;
            led_ms_reg   <= led_ms_next;
            led_reg      <= led_next;
        end
    end

`ifndef SYNTHESIS
    a_alarm_needs_alert: assert property (@(posedge clk) disable iff (!rst_n)
        alarm_reg |-> alert_reg)
        else $error("sos pattern running without an alert");

    a_led_needs_flashing: assert property (@(posedge clk) disable iff (!rst_n)
        led_reg |-> flashing_reg)
        else $error("led lit while not flashing");

    a_pending_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg == (count_reg != '0))
        else $error("pending press and press count disagree");

    a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg < STEP_IDX_W'(SOS_STEPS))
        else $error("sos step out of range");

    a_fire_clears_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && result.alert_fired) |=> !pending_reg && alert_reg == $past(result.alert_on))
        else $error("fired alert left a press pending");
`endif

endmodule
